@@ rtl/core/pbrq_pkg.sv @@
package pbrq_pkg;

    localparam int TASK_COUNT_DEF  = 64;
    localparam int LEVEL_COUNT_DEF = 32;

    localparam int KIND_W  = 2;
    localparam int TASK_W  = 6;
    localparam int LEVEL_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_SCHED = 2'd1,
        KIND_KILL  = 2'd2,
        KIND_PASS  = 2'd3
    } kind_t;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        kind_t              kind;
        logic [TASK_W-1:0]  task_id;
        logic [LEVEL_W-1:0] level;
    } req_t;

    typedef struct packed {
        logic [TASK_W-1:0] chosen_task;
        logic              has_task;
        logic              status;
    } rsp_t;

    // ready-mask update request from the sequencer
    typedef struct packed {
        logic               set;
        logic               clr;
        logic [LEVEL_W-1:0] idx;
    } mask_cmd_t;

endpackage

@@ rtl/core/pbrq_ram.sv @@
module pbrq_ram
    import pbrq_pkg::*;
#(
    parameter int DEPTH = TASK_COUNT_DEF,
    parameter int WIDTH = TASK_W
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next enabled read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/pbrq_sched.sv @@
module pbrq_sched
    import pbrq_pkg::*;
#(
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mask_cmd_t          cmd,
    input  logic [LEVEL_W-1:0] query_level,
    output logic               query_busy,
    output logic               any_ready,
    output logic [LEVEL_W-1:0] top_level
);

    logic [LEVEL_COUNT-1:0] mask_reg;
    logic [LEVEL_COUNT-1:0] mask_next;
    logic [31:0]            mask_pad;

    // levels beyond the configured count read as empty
    assign mask_pad   = 32'(mask_reg);
    assign query_busy = mask_pad[query_level];
    assign any_ready  = |mask_reg;

    // lowest set index is the most urgent level
    always_comb
    begin
        top_level = '0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                top_level = LEVEL_W'(i);
            end
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.set)
        begin
            mask_next = mask_next | LEVEL_COUNT'(32'd1 << cmd.idx);
        end
        if (cmd.clr)
        begin
            mask_next = mask_next & ~LEVEL_COUNT'(32'd1 << cmd.idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

endmodule

@@ rtl/core/priority_bitmap_ready_queue.sv @@
// Add, schedule, and kill or pass on an empty or single-task level finish after the level
// table read (S_LVL); kill or pass on a level with two or more tasks also reads the link memory.
// A new request is taken only in S_IDLE, after the previous response has entered the output
// register; a response that cannot enter it yet is parked in S_HOLD until rsp_ready frees it.
// Reset clears the ready mask and control state; the level table and link memory
// are not cleared and hold nothing meaningful until written.
module priority_bitmap_ready_queue
    import pbrq_pkg::*;
#(
    parameter int TASK_COUNT  = TASK_COUNT_DEF,
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int LINK_AW = $clog2(TASK_COUNT);
    localparam int LVL_AW  = $clog2(LEVEL_COUNT);
    localparam int ENTRY_W = 2 * TASK_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LVL,
        S_LINK,
        S_HOLD
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    logic   busy_reg, busy_next;
    rsp_t   rsp_reg, rsp_next;
    logic   rsp_valid_reg, rsp_valid_next;
    rsp_t   hold_reg, hold_next;

    logic               accept;
    logic               query_busy;
    logic               any_ready;
    logic [LEVEL_W-1:0] top_level;
    mask_cmd_t          mask_cmd;

    logic               lvl_rd_en;
    logic [LVL_AW-1:0]  lvl_rd_addr;
    logic [ENTRY_W-1:0] lvl_rd_data;
    logic               lvl_wr_en;
    logic [LVL_AW-1:0]  lvl_wr_addr;
    logic [ENTRY_W-1:0] lvl_wr_data;

    logic               link_rd_en;
    logic [LINK_AW-1:0] link_rd_addr;
    logic [TASK_W-1:0]  link_rd_data;
    logic               link_wr_en;
    logic [LINK_AW-1:0] link_wr_addr;
    logic [TASK_W-1:0]  link_wr_data;

    logic [TASK_W-1:0]  head;
    logic [TASK_W-1:0]  tail;
    logic               add_ok;
    logic               finish;
    logic               out_free;
    rsp_t               result;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign head   = lvl_rd_data[ENTRY_W-1:TASK_W];
    assign tail   = lvl_rd_data[TASK_W-1:0];
    assign add_ok = (6'(req_reg.level) < 6'(LEVEL_COUNT))
                    && (11'(req_reg.task_id) < 11'(TASK_COUNT));

    pbrq_sched #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (mask_cmd),
        .query_level (req.level),
        .query_busy  (query_busy),
        .any_ready   (any_ready),
        .top_level   (top_level)
    );

    pbrq_ram #(
        .DEPTH (LEVEL_COUNT),
        .WIDTH (ENTRY_W)
    ) u_level_ram (
        .clk     (clk),
        .rd_en   (lvl_rd_en),
        .rd_addr (lvl_rd_addr),
        .rd_data (lvl_rd_data),
        .wr_en   (lvl_wr_en),
        .wr_addr (lvl_wr_addr),
        .wr_data (lvl_wr_data)
    );

    pbrq_ram #(
        .DEPTH (TASK_COUNT),
        .WIDTH (TASK_W)
    ) u_link_ram (
        .clk     (clk),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data)
    );

    // schedule reads the head of the most urgent level, the rest read their own level
    assign lvl_rd_en   = accept;
    assign lvl_rd_addr = (req.kind == KIND_SCHED) ? LVL_AW'(top_level) : LVL_AW'(req.level);
    assign lvl_wr_addr = LVL_AW'(req_reg.level);
    assign link_rd_addr = LINK_AW'(head);
    assign link_wr_addr = LINK_AW'(tail);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        busy_next      = busy_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        hold_next      = hold_reg;

        mask_cmd     = '{set: 1'b0, clr: 1'b0, idx: req_reg.level};
        lvl_wr_en    = 1'b0;
        lvl_wr_data  = {head, tail};
        link_rd_en   = 1'b0;
        link_wr_en   = 1'b0;
        link_wr_data = req_reg.task_id;
        finish       = 1'b0;
        result       = '{chosen_task: '0, has_task: 1'b0, status: STATUS_OK};

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req;
                    busy_next  = query_busy;
                    state_next = S_LVL;
                end
            end
            S_LVL:
            begin
                case (req_reg.kind)
                    KIND_ADD:
                    begin
                        if (add_ok)
                        begin
                            // append behind the old tail, or start a fresh list
                            link_wr_en   = busy_reg;
                            link_wr_data = req_reg.task_id;
                            lvl_wr_en    = 1'b1;
                            lvl_wr_data  = {busy_reg ? head : req_reg.task_id,
                                            req_reg.task_id};
                            mask_cmd.set = 1'b1;
                        end
                        finish = 1'b1;
                    end
                    KIND_SCHED:
                    begin
                        result.chosen_task = any_ready ? head : '0;
                        result.has_task    = any_ready;
                        finish             = 1'b1;
                    end
                    default:
                    begin
                        if (!busy_reg)
                        begin
                            result.status = STATUS_EMPTY;
                            finish        = 1'b1;
                        end
                        else if (head == tail)
                        begin
                            // single entry: kill empties the level, pass leaves it alone
                            mask_cmd.clr = (req_reg.kind == KIND_KILL);
                            finish       = 1'b1;
                        end
                        else
                        begin
                            link_rd_en = 1'b1;
                            state_next = S_LINK;
                        end
                    end
                endcase
            end
            S_LINK:
            begin
                lvl_wr_en = 1'b1;
                if (req_reg.kind == KIND_PASS)
                begin
                    // rotate: old head goes behind the tail
                    link_wr_en   = 1'b1;
                    link_wr_data = head;
                    lvl_wr_data  = {link_rd_data, head};
                end
                else
                begin
                    lvl_wr_data = {link_rd_data, tail};
                end
                finish = 1'b1;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    rsp_next       = hold_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            if (out_free)
            begin
                rsp_next       = result;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                hold_next  = result;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            busy_reg      <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        rsp_reg  <= rsp_next;
        hold_reg <= hold_next;
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_HOLD) |-> (!lvl_wr_en && !link_wr_en))
        else $error("table write outside an active request");

    a_link_rd_src: assert property (@(posedge clk) disable iff (!rst_n)
        link_rd_en |-> (state_reg == S_LVL
                        && (req_reg.kind == KIND_KILL || req_reg.kind == KIND_PASS)))
        else $error("link read from an unexpected request");

    a_link_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LINK |-> busy_reg)
        else $error("link stage entered on an empty level");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HOLD |-> rsp_valid_reg)
        else $error("response parked while output register empty");

    a_has_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.has_task) |-> (rsp_reg.status == STATUS_OK))
        else $error("found task reported with error status");

endmodule
